// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle implication failed.");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle implication failed.");

`endif

// ===== hdl/aou_pkg.sv =====
// ----------------------------------------------------------------------------
// Adam optimizer update package
// Types, register codes, widths and reset values shared by the update block.
// ----------------------------------------------------------------------------
package aou_pkg;

    localparam int NUM_ELEMENTS = 1024;
    localparam int IDX_W        = $clog2(NUM_ELEMENTS);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FIRST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_SECOND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd2;

    localparam logic [15:0] DECAY_FIRST_RST   = 16'd58982;
    localparam logic [15:0] DECAY_SECOND_RST  = 16'd65470;
    localparam logic [23:0] LEARNING_RATE_RST = 24'd16777;

    // Powers are Q1.31; one means the first epoch.
    localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
    localparam logic [31:0] CUR1_RST = 32'((64'(ONE_Q31) * 64'(DECAY_FIRST_RST)) >> 16);
    localparam logic [31:0] CUR2_RST = 32'((64'(ONE_Q31) * 64'(DECAY_SECOND_RST)) >> 16);

    localparam logic [32:0] EPS_Q24 = 33'd168;

    // Pipelined restoring divider: 63-bit dividend, 32-bit divisor, 33 quotient bits.
    localparam int DIV_N_W = 63;
    localparam int DIV_D_W = 32;
    localparam int DIV_Q_W = 33;
    localparam int DIV_LAT = DIV_Q_W + 1;

    // Pipelined square root of a 58-bit radicand.
    localparam int SQ_X_W   = 58;
    localparam int ROOT_W   = SQ_X_W / 2;
    localparam int SQ_REM_W = ROOT_W + 2;
    localparam int SQ_STEPS = ROOT_W;

    typedef struct packed {
        logic [9:0]         element_index;
        logic signed [31:0] param_value;
        logic signed [31:0] grad_value;
        logic               pass_last;
    } aou_in_t;

    typedef struct packed {
        logic signed [31:0] new_value;
        logic               saturated;
    } aou_out_t;

endpackage

// ===== hdl/aou_divider.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per stage, with overflow detection
// for quotients that do not fit in the quotient width.
// ----------------------------------------------------------------------------
module aou_divider (
    input  logic                        clk,
    input  logic                        en,
    input  logic [aou_pkg::DIV_N_W-1:0] dividend,
    input  logic [aou_pkg::DIV_D_W-1:0] divisor,
    output logic [aou_pkg::DIV_Q_W-1:0] quotient,
    output logic                        overflow
);
    import aou_pkg::*;

    typedef struct packed {
        logic [DIV_D_W-1:0] rem;
        logic [DIV_Q_W-1:0] low;
        logic [DIV_D_W-1:0] den;
        logic [DIV_Q_W-1:0] quo;
        logic               ovf;
    } div_st_t;

    div_st_t st_reg  [DIV_LAT];
    div_st_t st_next [DIV_LAT];

    logic [DIV_D_W-1:0] high;

    function automatic div_st_t div_step(div_st_t s);
        div_st_t          r;
        logic [DIV_D_W:0] t;
        logic             ge;
        r     = s;
        t     = {s.rem, s.low[DIV_Q_W-1]};
        ge    = t >= {1'b0, s.den};
        r.rem = ge ? DIV_D_W'(t - {1'b0, s.den}) : t[DIV_D_W-1:0];
        r.low = {s.low[DIV_Q_W-2:0], 1'b0};
        r.quo = {s.quo[DIV_Q_W-2:0], ge};
        return r;
    endfunction

    // The quotient overflows when the bits above the quotient span already
    // reach the divisor.
    assign high = DIV_D_W'(dividend[DIV_N_W-1:DIV_Q_W]);

    always_comb
    begin
        st_next[0] = '{rem: high, low: dividend[DIV_Q_W-1:0], den: divisor,
                       quo: '0, ovf: (high >= divisor)};
        for (int k = 1; k < DIV_LAT; k++)
        begin
            st_next[k] = div_step(st_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_LAT; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign quotient = st_reg[DIV_LAT-1].quo;
    assign overflow = st_reg[DIV_LAT-1].ovf;

endmodule

// ===== hdl/adam_optimizer_update_top.sv =====
// ----------------------------------------------------------------------------
// Adam optimizer update with bias correction
// One transaction per cycle while in_ready is high; output back-pressure also lowers it.
// Items hitting an element still in the four moment stages stall input until it is written.
// A configuration write holds in_ready low for the following cycle while the powers settle.
// Reset: a clearing pass over all 1024 entries of the moment memories runs with in_ready low.
// ----------------------------------------------------------------------------
module adam_optimizer_update_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [aou_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aou_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  aou_pkg::aou_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output aou_pkg::aou_out_t              out_data
);
    import aou_pkg::*;

    typedef struct packed {
        logic signed [31:0] param;
        logic               neg;
        logic               sat;
    } side_t;

    typedef struct packed {
        logic [SQ_X_W-1:0]   x;
        logic [ROOT_W-1:0]   root;
        logic [SQ_REM_W-1:0] rem;
        logic [31:0]         mh;
        side_t               side;
    } sq_st_t;

    function automatic sq_st_t sqrt_step(sq_st_t s);
        sq_st_t              r;
        logic [SQ_REM_W+1:0] t;
        logic [SQ_REM_W+1:0] trial;
        logic                ge;
        r      = s;
        t      = {s.rem, s.x[SQ_X_W-1 -: 2]};
        trial  = {2'b00, s.root, 2'b01};
        ge     = t >= trial;
        r.x    = {s.x[SQ_X_W-3:0], 2'b00};
        r.root = {s.root[ROOT_W-2:0], ge};
        r.rem  = ge ? SQ_REM_W'(t - trial) : SQ_REM_W'(t);
        return r;
    endfunction

    // Configuration and powers.
    logic [15:0] b1_reg;
    logic [15:0] b2_reg;
    logic [23:0] eta_reg;
    logic [31:0] pow1_reg;
    logic [31:0] pow2_reg;
    logic [31:0] cur1_reg;
    logic [31:0] cur2_reg;
    logic [31:0] pmul1_a;
    logic [31:0] pmul2_a;
    logic [47:0] cur1_prod;
    logic [47:0] cur2_prod;
    logic        cfg_settle_reg;

    // Clearing pass and handshake.
    logic             clearing_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic             en;
    logic             hazard;
    logic             in_accept;
    logic [IDX_W-1:0] rd_addr;

    // Moment memories.
    logic signed [31:0] m_mem [NUM_ELEMENTS];
    logic [31:0]        v_mem [NUM_ELEMENTS];
    logic signed [31:0] m_rd_reg;
    logic [31:0]        v_rd_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_addr;
    logic signed [31:0] mem_m;
    logic [31:0]        mem_v;

    // Moment stages.
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [IDX_W-1:0]   s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic signed [31:0] s1_param_reg, s2_param_reg, s3_param_reg, s4_param_reg;
    logic [31:0]        s1_den1_reg, s2_den1_reg, s3_den1_reg, s4_den1_reg;
    logic [31:0]        s1_den2_reg, s2_den2_reg, s3_den2_reg, s4_den2_reg;
    logic signed [31:0] s1_grad_reg;
    logic signed [48:0] s2_prod_m_reg;
    logic signed [48:0] s2_prod_g_reg;
    logic [63:0]        s2_gg_reg;
    logic [47:0]        s2_b2v_reg, s3_b2v_reg;
    logic signed [31:0] s3_m_reg, s4_m_reg;
    logic [31:0]        s3_sq_reg;
    logic               s3_sat_reg, s4_sat_reg;
    logic [31:0]        s4_v_reg;
    logic [31:0]        s4_mmag_reg;
    logic               s4_neg_reg;

    logic signed [16:0] b1_s;
    logic signed [17:0] w1_s;
    logic signed [48:0] prod_m_c;
    logic signed [48:0] prod_g_c;
    logic [31:0]        g_u;
    logic [31:0]        gmag;
    logic [63:0]        gg_c;
    logic [47:0]        b2v_c;
    logic signed [49:0] msum;
    logic signed [33:0] msh;
    logic signed [31:0] m_c;
    logic [31:0]        sq_c;
    logic               sq_sat;
    logic [16:0]        w2;
    logic [48:0]        vprod;
    logic [49:0]        vsum;
    logic [31:0]        v_c;
    logic [31:0]        m_u;
    logic [31:0]        mmag_c;

    // Correction dividers and square root.
    logic [DIV_Q_W-1:0] q1, q2, q3;
    logic               ovf1, ovf2, ovf3;
    logic               d1_valid_reg [DIV_LAT];
    side_t              d1_side_reg  [DIV_LAT];
    side_t              d1_side;
    logic               mh_clip, vh_clip;
    logic [31:0]        mh_c;
    logic [31:0]        vh_c;
    logic               a_valid_reg;
    sq_st_t             a_st_reg;
    logic               sq_valid_reg [SQ_STEPS];
    sq_st_t             sq_reg       [SQ_STEPS];
    sq_st_t             sq_next      [SQ_STEPS];

    // Step stages.
    logic               p_valid_reg;
    logic [55:0]        p_prod_reg;
    logic [ROOT_W-1:0]  p_root_reg;
    side_t              p_side_reg;
    logic               d3_valid_reg [DIV_LAT];
    side_t              d3_side_reg  [DIV_LAT];
    side_t              d3_side;
    logic [33:0]        smag;
    logic signed [34:0] step_s;
    logic signed [34:0] nv;
    aou_out_t           f_c;

    // Tail and output skid.
    logic               f_valid_reg;
    aou_out_t           f_data_reg;
    logic               out_valid_reg;
    aou_out_t           out_data_reg;
    logic               skid_valid_reg;
    aou_out_t           skid_data_reg;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_reg  <= DECAY_FIRST_RST;
            b2_reg  <= DECAY_SECOND_RST;
            eta_reg <= LEARNING_RATE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DECAY_FIRST:   b1_reg  <= cfg_data[15:0];
                CFG_DECAY_SECOND:  b2_reg  <= cfg_data[15:0];
                CFG_LEARNING_RATE: eta_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // The current powers follow a rate write once the rate register and then the power registers load.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_settle_reg <= 1'b0;
        end
        else
        begin
            cfg_settle_reg <= cfg_write;
        end
    end

    // The current power is kept one epoch ahead of the stored power, so the
    // item after a pass end sees the new value without a bubble.
    assign pmul1_a   = (in_accept && in_data.pass_last) ? cur1_reg : pow1_reg;
    assign pmul2_a   = (in_accept && in_data.pass_last) ? cur2_reg : pow2_reg;
    assign cur1_prod = 48'(pmul1_a) * 48'(b1_reg);
    assign cur2_prod = 48'(pmul2_a) * 48'(b2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pow1_reg <= ONE_Q31;
            pow2_reg <= ONE_Q31;
            cur1_reg <= CUR1_RST;
            cur2_reg <= CUR2_RST;
        end
        else
        begin
            if (in_accept && in_data.pass_last)
            begin
                pow1_reg <= cur1_reg;
                pow2_reg <= cur2_reg;
            end
            cur1_reg <= cur1_prod[47:16];
            cur2_reg <= cur2_prod[47:16];
        end
    end

    // ------------------------------------------------------------------
    // Clearing pass and input handshake
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == IDX_W'(NUM_ELEMENTS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    assign en      = !skid_valid_reg;
    assign rd_addr = in_data.element_index[IDX_W-1:0];
    assign hazard  = (s1_valid_reg && (s1_idx_reg == rd_addr))
                  || (s2_valid_reg && (s2_idx_reg == rd_addr))
                  || (s3_valid_reg && (s3_idx_reg == rd_addr))
                  || (s4_valid_reg && (s4_idx_reg == rd_addr));
    assign in_ready  = en && !clearing_reg && !cfg_settle_reg && !hazard;
    assign in_accept = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Moment memories
    // ------------------------------------------------------------------
    assign mem_we   = clearing_reg || (s4_valid_reg && en);
    assign mem_addr = clearing_reg ? clr_cnt_reg : s4_idx_reg;
    assign mem_m    = clearing_reg ? '0 : s4_m_reg;
    assign mem_v    = clearing_reg ? '0 : s4_v_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            m_mem[mem_addr] <= mem_m;
            v_mem[mem_addr] <= mem_v;
        end
        if (en)
        begin
            m_rd_reg <= m_mem[rd_addr];
            v_rd_reg <= v_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Moment stages
    // ------------------------------------------------------------------
    assign b1_s     = signed'({1'b0, b1_reg});
    assign w1_s     = signed'(18'h10000 - {2'b00, b1_reg});
    assign prod_m_c = b1_s * m_rd_reg;
    assign prod_g_c = w1_s * s1_grad_reg;
    assign g_u      = s1_grad_reg;
    assign gmag     = g_u[31] ? (~g_u + 32'd1) : g_u;
    assign gg_c     = 64'(gmag) * 64'(gmag);
    assign b2v_c    = 48'(b2_reg) * 48'(v_rd_reg);

    // Adding half and shifting arithmetically rounds ties toward plus infinity.
    assign msum   = 50'(s2_prod_m_reg) + 50'(s2_prod_g_reg) + 50'sd32768;
    assign msh    = msum[49:16];
    assign sq_sat = |s2_gg_reg[63:56];
    assign sq_c   = sq_sat ? 32'hFFFF_FFFF : s2_gg_reg[55:24];

    always_comb
    begin
        if (msh > 34'sd2147483647)
        begin
            m_c = 32'sh7FFF_FFFF;
        end
        else if (msh < -34'sd2147483648)
        begin
            m_c = 32'sh8000_0000;
        end
        else
        begin
            m_c = msh[31:0];
        end
    end

    assign w2     = 17'h10000 - {1'b0, b2_reg};
    assign vprod  = 49'(w2) * 49'(s3_sq_reg);
    assign vsum   = 50'(s3_b2v_reg) + 50'(vprod) + 50'd32768;
    assign v_c    = (|vsum[49:48]) ? 32'hFFFF_FFFF : vsum[47:16];
    assign m_u    = s3_m_reg;
    assign mmag_c = m_u[31] ? (~m_u + 32'd1) : m_u;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_idx_reg    <= rd_addr;
            s1_param_reg  <= in_data.param_value;
            s1_grad_reg   <= in_data.grad_value;
            s1_den1_reg   <= ONE_Q31 - cur1_reg;
            s1_den2_reg   <= ONE_Q31 - cur2_reg;

            s2_idx_reg    <= s1_idx_reg;
            s2_param_reg  <= s1_param_reg;
            s2_den1_reg   <= s1_den1_reg;
            s2_den2_reg   <= s1_den2_reg;
            s2_prod_m_reg <= prod_m_c;
            s2_prod_g_reg <= prod_g_c;
            s2_gg_reg     <= gg_c;
            s2_b2v_reg    <= b2v_c;

            s3_idx_reg    <= s2_idx_reg;
            s3_param_reg  <= s2_param_reg;
            s3_den1_reg   <= s2_den1_reg;
            s3_den2_reg   <= s2_den2_reg;
            s3_m_reg      <= m_c;
            s3_sq_reg     <= sq_c;
            s3_sat_reg    <= sq_sat;
            s3_b2v_reg    <= s2_b2v_reg;

            s4_idx_reg    <= s3_idx_reg;
            s4_param_reg  <= s3_param_reg;
            s4_den1_reg   <= s3_den1_reg;
            s4_den2_reg   <= s3_den2_reg;
            s4_m_reg      <= s3_m_reg;
            s4_v_reg      <= v_c;
            s4_mmag_reg   <= mmag_c;
            s4_neg_reg    <= s3_m_reg[31];
            s4_sat_reg    <= s3_sat_reg;
        end
    end

    // ------------------------------------------------------------------
    // Bias correction: m_hat and v_hat
    // ------------------------------------------------------------------
    aou_divider u_div_m (
        .clk      (clk),
        .en       (en),
        .dividend ({s4_mmag_reg, 31'b0}),
        .divisor  (s4_den1_reg),
        .quotient (q1),
        .overflow (ovf1)
    );

    aou_divider u_div_v (
        .clk      (clk),
        .en       (en),
        .dividend ({s4_v_reg, 31'b0}),
        .divisor  (s4_den2_reg),
        .quotient (q2),
        .overflow (ovf2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_LAT; k++)
            begin
                d1_valid_reg[k] <= 1'b0;
                d3_valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            d1_valid_reg[0] <= s4_valid_reg;
            d3_valid_reg[0] <= p_valid_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                d1_valid_reg[k] <= d1_valid_reg[k-1];
                d3_valid_reg[k] <= d3_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_side_reg[0] <= '{param: s4_param_reg, neg: s4_neg_reg, sat: s4_sat_reg};
            d3_side_reg[0] <= p_side_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                d1_side_reg[k] <= d1_side_reg[k-1];
                d3_side_reg[k] <= d3_side_reg[k-1];
            end
        end
    end

    assign d1_side = d1_side_reg[DIV_LAT-1];

    // A negative m_hat may reach one more than a positive one.
    assign mh_clip = ovf1 || (d1_side.neg ? (q1 > 33'h0_8000_0000) : (q1 > 33'h0_7FFF_FFFF));
    assign mh_c    = mh_clip ? (d1_side.neg ? 32'h8000_0000 : 32'h7FFF_FFFF) : q1[31:0];
    assign vh_clip = ovf2 || q2[DIV_Q_W-1];
    assign vh_c    = vh_clip ? 32'hFFFF_FFFF : q2[31:0];

    // ------------------------------------------------------------------
    // Square root of (v_hat + eps) in Q.24
    // ------------------------------------------------------------------
    always_comb
    begin
        sq_next[0] = sqrt_step(a_st_reg);
        for (int j = 1; j < SQ_STEPS; j++)
        begin
            sq_next[j] = sqrt_step(sq_reg[j-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            for (int j = 0; j < SQ_STEPS; j++)
            begin
                sq_valid_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            a_valid_reg     <= d1_valid_reg[DIV_LAT-1];
            sq_valid_reg[0] <= a_valid_reg;
            for (int j = 1; j < SQ_STEPS; j++)
            begin
                sq_valid_reg[j] <= sq_valid_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_st_reg.x    <= {1'b0, 33'(vh_c) + EPS_Q24, 24'b0};
            a_st_reg.root <= '0;
            a_st_reg.rem  <= '0;
            a_st_reg.mh   <= mh_c;
            a_st_reg.side <= '{param: d1_side.param, neg: d1_side.neg,
                              sat: d1_side.sat | mh_clip | vh_clip};
            for (int j = 0; j < SQ_STEPS; j++)
            begin
                sq_reg[j] <= sq_next[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Step = |m_hat| * eta / root, then the saturated subtraction
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= sq_valid_reg[SQ_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_prod_reg <= 56'(sq_reg[SQ_STEPS-1].mh) * 56'(eta_reg);
            p_root_reg <= sq_reg[SQ_STEPS-1].root;
            p_side_reg <= sq_reg[SQ_STEPS-1].side;
        end
    end

    // The root is at least sqrt(eps) in Q.24, so the divisor is never zero.
    aou_divider u_div_s (
        .clk      (clk),
        .en       (en),
        .dividend (DIV_N_W'(p_prod_reg)),
        .divisor  (DIV_D_W'(p_root_reg)),
        .quotient (q3),
        .overflow (ovf3)
    );

    assign d3_side = d3_side_reg[DIV_LAT-1];

    // A step of 2^33 or more saturates the result whatever the value.
    assign smag   = ovf3 ? {1'b0, {DIV_Q_W{1'b1}}} : {1'b0, q3};
    assign step_s = d3_side.neg ? -signed'({1'b0, smag}) : signed'({1'b0, smag});
    assign nv     = 35'(d3_side.param) - step_s;

    always_comb
    begin
        if (nv > 35'sd2147483647)
        begin
            f_c.new_value = 32'sh7FFF_FFFF;
            f_c.saturated = 1'b1;
        end
        else if (nv < -35'sd2147483648)
        begin
            f_c.new_value = 32'sh8000_0000;
            f_c.saturated = 1'b1;
        end
        else
        begin
            f_c.new_value = nv[31:0];
            f_c.saturated = d3_side.sat;
        end
    end

    // ------------------------------------------------------------------
    // Tail register, output register and skid
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= d3_valid_reg[DIV_LAT-1];
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= f_valid_reg;
            end
            else
            begin
                out_valid_reg <= f_valid_reg;
            end
        end
        else if (out_ready)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_data_reg <= f_c;
            if (out_valid_reg && !out_ready)
            begin
                skid_data_reg <= f_data_reg;
            end
            else
            begin
                out_data_reg <= f_data_reg;
            end
        end
        else if (out_ready)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/aou_checker.sv =====
// ----------------------------------------------------------------------------
// Adam update port checker
// Watches the top-level ports for held results, invented results and the
// clearing pass after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aou_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input aou_pkg::aou_out_t out_data
);
    import aou_pkg::*;

    // Transactions accepted at the input but not yet delivered.
    logic [7:0] pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
        end
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `ASSERT_IMPL(a_no_invented, clk, rst_n, out_valid, pending_reg != 8'd0)
    `ASSERT_IMPL(a_clear_after_reset, clk, rst_n, !$past(rst_n), !in_ready)

endmodule

bind adam_optimizer_update_top aou_checker u_aou_checker (.*);

// ===== verif/tb_adam_optimizer_update_top.sv =====
// ----------------------------------------------------------------------------
// Adam optimizer update testbench
// Streams parameter/gradient transactions into the update block with random
// stalls on both sides and compares every result against a bit-exact
// predictor of the moment, bias-correction and step arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_adam_optimizer_update_top;
    import aou_pkg::*;

    localparam int MAX_CYCLES = 2000000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    aou_in_t               in_data;
    logic                  out_valid;
    logic                  out_ready;
    aou_out_t              out_data;

    adam_optimizer_update_top DUT (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data)
    );

    // Predictor state.
    logic [15:0]        b1_reg;
    logic [15:0]        b2_reg;
    logic [23:0]        eta_reg;
    logic signed [31:0] m_store [NUM_ELEMENTS];
    logic [31:0]        v_store [NUM_ELEMENTS];
    logic [31:0]        pow1;
    logic [31:0]        pow2;

    aou_in_t  pending_items[$];
    aou_out_t expected_updates[$];
    int       cycle_count = 0;
    int       mismatches = 0;
    int       results_seen = 0;
    int       sat_seen = 0;
    bit       quiet_sender;
    bit       quiet_receiver;
    bit       hold_sender;

    function automatic longint round_down16(longint x);
        longint t;
        t = x + 32768;
        if (t >= 0)
            return t >>> 16;
        return -(((-t) + 65535) >>> 16);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic aou_out_t adam_update(aou_in_t item);
        int unsigned     idx;
        longint          prm;
        longint          grd;
        longint          b1;
        longint unsigned b2;
        longint          m;
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned v;
        longint unsigned c1;
        longint unsigned c2;
        longint unsigned den1;
        longint unsigned den2;
        longint unsigned mmag;
        longint unsigned mh;
        longint unsigned vh;
        longint unsigned r;
        longint unsigned smag;
        longint          stp;
        longint          nv;
        bit              sat;
        aou_out_t        res;
        idx = item.element_index % NUM_ELEMENTS;
        prm = item.param_value;
        grd = item.grad_value;
        b1 = b1_reg;
        b2 = b2_reg;
        sat = 0;
        m = round_down16(b1 * longint'(m_store[idx]) + (65536 - b1) * grd);
        if (m > 64'sd2147483647) m = 64'sd2147483647;
        if (m < -64'sd2147483648) m = -64'sd2147483648;
        m_store[idx] = m[31:0];
        mag = (grd < 0) ? -grd : grd;
        sq = (mag * mag) >> 24;
        if (sq > 64'hFFFF_FFFF) begin
            sq = 64'hFFFF_FFFF;
            sat = 1;
        end
        v = (b2 * v_store[idx] + (65536 - b2) * sq + 32768) >> 16;
        if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        v_store[idx] = v[31:0];
        c1 = (64'(pow1) * b1_reg) >> 16;
        c2 = (64'(pow2) * b2_reg) >> 16;
        c1 &= 64'hFFFF_FFFF;
        c2 &= 64'hFFFF_FFFF;
        den1 = 64'h8000_0000 - c1;
        den2 = 64'h8000_0000 - c2;
        if (den1 == 0) den1 = 1;
        if (den2 == 0) den2 = 1;
        mmag = (m < 0) ? -m : m;
        mh = (mmag << 31) / den1;
        if (m >= 0 && mh > 64'h7FFF_FFFF) begin
            mh = 64'h7FFF_FFFF;
            sat = 1;
        end
        if (m < 0 && mh > 64'h8000_0000) begin
            mh = 64'h8000_0000;
            sat = 1;
        end
        vh = (v << 31) / den2;
        if (vh > 64'hFFFF_FFFF) begin
            vh = 64'hFFFF_FFFF;
            sat = 1;
        end
        r = int_sqrt((vh + 168) << 24);
        if (r == 0) r = 1;
        smag = (mh * eta_reg) / r;
        stp = (m < 0) ? -longint'(smag) : longint'(smag);
        nv = prm - stp;
        if (nv > 64'sd2147483647) begin
            nv = 64'sd2147483647;
            sat = 1;
        end
        if (nv < -64'sd2147483648) begin
            nv = -64'sd2147483648;
            sat = 1;
        end
        if (item.pass_last) begin
            pow1 = c1[31:0];
            pow2 = c2[31:0];
        end
        res.new_value = nv[31:0];
        res.saturated = sat;
        return res;
    endfunction

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_updates = {expected_updates, adam_update(in_data)};
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && !hold_sender &&
                    (quiet_sender || $urandom_range(99) >= 35))
                begin
                    in_valid <= 1;
                    in_data  <= pending_items.pop_front();
                end
                else
                    in_valid <= 0;
            end
        end
    end

    // Monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_updates.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result %h", out_data);
                end
                else
                begin
                    aou_out_t exp_upd;
                    exp_upd = expected_updates.pop_front();
                    if (exp_upd.saturated) sat_seen++;
                    if (out_data.new_value !== exp_upd.new_value ||
                        out_data.saturated !== exp_upd.saturated)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d new_value exp %h got %h, sat exp %b got %b",
                                     results_seen, exp_upd.new_value, out_data.new_value,
                                     exp_upd.saturated, out_data.saturated);
                    end
                end
            end
            out_ready <= quiet_receiver || ($urandom_range(99) >= 35);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("tb_adam_optimizer_update_top NOT OK");
            $finish;
        end
    end

    task automatic add_item(int idx, logic [31:0] p, logic [31:0] g, bit last);
        aou_in_t it;
        it.element_index = 10'(idx);
        it.param_value   = p;
        it.grad_value    = g;
        it.pass_last     = last;
        pending_items = {pending_items, it};
    endtask

    // Random pass over a small window of elements; mostly small gradients.
    task automatic add_pass(int n);
        int base;
        logic [31:0] g;
        base = $urandom_range(1023);
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(9))
                0: g = $urandom;
                1: g = {$urandom_range(1) ? 8'hFF : 8'h00, 24'($urandom)};
                default: g = 32'($signed(17'($urandom)) * 64);
            endcase
            add_item((base + k * 7) % 1024, $urandom, g, k == n - 1);
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_valid || expected_updates.size() > 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 0;
        case (idx)
            CFG_DECAY_FIRST:   b1_reg = val[15:0];
            CFG_DECAY_SECOND:  b2_reg = val[15:0];
            CFG_LEARNING_RATE: eta_reg = val;
            default: ;
        endcase
    endtask

    initial
    begin
        int phase_items;
        cfg_write = 0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n = 0;
        quiet_sender = 0;
        quiet_receiver = 0;
        hold_sender = 1;
        b1_reg = DECAY_FIRST_RST;
        b2_reg = DECAY_SECOND_RST;
        eta_reg = LEARNING_RATE_RST;
        pow1 = ONE_Q31;
        pow2 = ONE_Q31;
        for (int i = 0; i < NUM_ELEMENTS; i++)
        begin
            m_store[i] = 0;
            v_store[i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1;

        // Directed: field extremes, pass ends, repeated element.
        add_item(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        add_item(1023, 32'h8000_0000, 32'h8000_0000, 0);
        add_item(5, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        add_item(5, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        add_item(5, 0, 32'h0100_0000, 1);
        add_item(6, 32'h0100_0000, 0, 0);
        add_item(6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        add_item(1023, 32'h1234_5678, 32'h0000_0001, 1);
        add_item(512, 32'hFF00_0000, 32'hFFFF_0000, 1);
        hold_sender = 0;
        wait_drained();

        // Zero decay rates and the extreme learning rate.
        write_cfg(CFG_DECAY_FIRST, 24'd0);
        write_cfg(CFG_DECAY_SECOND, 24'd0);
        write_cfg(CFG_LEARNING_RATE, 24'hFF_FFFF);
        add_item(7, 32'h7FFF_0000, 32'h0200_0000, 1);
        add_item(8, 32'h8000_1000, 32'hFE00_0000, 1);
        add_item(7, 0, 32'h0000_0010, 0);
        wait_drained();

        write_cfg(CFG_DECAY_FIRST, 24'h00_FFFF);
        write_cfg(CFG_DECAY_SECOND, 24'h00_FFFF);
        write_cfg(CFG_LEARNING_RATE, 24'd0);
        add_item(9, 32'h0100_0000, 32'h0100_0000, 1);
        add_item(9, 32'h0100_0000, 32'hFF00_0000, 1);
        wait_drained();

        // Random phases, each under a fresh configuration.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_cfg(CFG_DECAY_FIRST, 24'((ph == 0) ? DECAY_FIRST_RST : $urandom));
            write_cfg(CFG_DECAY_SECOND, 24'((ph == 0) ? DECAY_SECOND_RST : $urandom));
            write_cfg(CFG_LEARNING_RATE, 24'((ph == 5) ? 24'd1 : $urandom));
            quiet_sender = (ph == 2);
            quiet_receiver = (ph == 2);
            phase_items = 0;
            while (phase_items < 160)
            begin
                int n;
                n = $urandom_range(1, 30);
                add_pass(n);
                phase_items += n;
                if ($urandom_range(5) == 0)
                begin
                    add_item($urandom, $urandom, $urandom, $urandom_range(1));
                    phase_items++;
                end
            end
            // Midway through phase 3 the sender holds off until every
            // outstanding result is back.
            if (ph == 3)
            begin
                while (pending_items.size() > phase_items / 2) @(posedge clk);
                hold_sender = 1;
                while (expected_updates.size() > 0 || in_valid) @(posedge clk);
                hold_sender = 0;
            end
            wait_drained();
        end

        $display("Checked %0d results over 9 configurations; %0d saturated.",
                 results_seen, sat_seen);
        if (mismatches == 0)
            $display("tb_adam_optimizer_update_top OK");
        else
            $display("tb_adam_optimizer_update_top NOT OK");
        $finish;
    end

endmodule
